FILE: hw/rtl/ysr_pkg.sv
// ----------------------------------------------------------------------------
// ysr_pkg
// Shared types, register indexes and constants for the YCbCr to RGB converter.
// ----------------------------------------------------------------------------
package ysr_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int HEIGHT_LIMIT  = 4096;
  localparam int ROW_W         = 12;
  localparam int CFG_DW        = 13;
  localparam int CFG_AW        = 2;
  localparam int QDEPTH        = 4;

  localparam logic [CFG_AW-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_AW-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_HEIGHT = 2'd2;

  localparam logic [CFG_DW-1:0] WIDTH_RST  = 13'd640;
  localparam logic [CFG_DW-1:0] HEIGHT_RST = 13'd480;

  typedef enum logic [1:0] {
    MODE_420 = 2'd0,
    MODE_422 = 2'd1,
    MODE_444 = 2'd2,
    MODE_RGB = 2'd3
  } mode_t;

  // BT.601 integer matrix
  localparam int COEF_Y    = 298;
  localparam int COEF_RCR  = 409;
  localparam int COEF_GCB  = 100;
  localparam int COEF_GCR  = 208;
  localparam int COEF_BCB  = 516;
  localparam int Y_OFFSET  = 16;
  localparam int C_OFFSET  = 128;
  localparam int ROUND_ADD = 128;
  localparam int BYTE_MAX  = 255;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } ysr_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } ysr_out_t;

  // one pixel between front and back: chroma already resolved
  typedef struct packed {
    logic       passthru;
    logic [7:0] luma;
    logic [7:0] cb;
    logic [7:0] cr;
    logic       frame_end;
  } ysr_item_t;

endpackage

FILE: hw/rtl/ycbcr_subsampled_to_rgb.sv
// ----------------------------------------------------------------------------
// ycbcr_subsampled_to_rgb
// Pixel-stream YCbCr (4:2:0 / 4:2:2 / 4:4:4) or RGB to clamped BT.601 RGB.
// ----------------------------------------------------------------------------
//  channel  | ports                         | beat
//  ---------+-------------------------------+-------------------------------
//  in       | in_valid, in_stall, in_data   | one pixel (Y, Cb, Cr)
//  out      | out_valid, out_stall, out_data| one RGB pixel + frame_end
//  cfg      | cfg_we, cfg_addr, cfg_wdata   | mode, width, height write
//
//  One pixel per cycle sustained while out_stall stays low; a result passes the
//  front stage with line store read, the queue, the product stage and the output register.
//  Reset: synchronous active-low; counters, held chroma and pipeline cleared,
//  line store contents left as they are.
//  Stalls: a 4-deep queue between front and back lets each side stall alone.
// ----------------------------------------------------------------------------
module ycbcr_subsampled_to_rgb
  import ysr_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ysr_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ysr_out_t          out_data,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  mode_t             mode_r;
  logic [CFG_DW-1:0] width_r;
  logic [CFG_DW-1:0] height_r;

  logic      push;
  ysr_item_t push_item;
  logic      q_ready;
  logic      q_valid;
  ysr_item_t q_item;
  logic      pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_420;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MODE:   mode_r   <= mode_t'(cfg_wdata[1:0]);
        REG_WIDTH:  width_r  <= cfg_wdata;
        REG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ysr_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .mode        (mode_r),
    .frame_width (width_r),
    .frame_height(height_r),
    .push        (push),
    .push_item   (push_item),
    .q_ready     (q_ready)
  );

  ysr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .q_ready  (q_ready),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .pop      (pop)
  );

  ysr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

FILE: hw/rtl/ysr_front.sv
// ----------------------------------------------------------------------------
// ysr_front
// Accepts pixels, tracks column/row, picks chroma per subsampling mode and
// keeps the 4:2:0 chroma line store.
// ----------------------------------------------------------------------------
module ysr_front
  import ysr_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ysr_in_t           in_data,
  input  mode_t             mode,
  input  logic [CFG_DW-1:0] frame_width,
  input  logic [CFG_DW-1:0] frame_height,
  output logic              push,
  output ysr_item_t         push_item,
  input  logic              q_ready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LD = (MAX_WIDTH + 1) / 2;
  localparam int AW = (LD > 1) ? $clog2(LD) : 1;

  typedef enum logic [1:0] {
    SEL_IN   = 2'd0,
    SEL_HELD = 2'd1,
    SEL_LINE = 2'd2
  } csel_t;

  logic [CW-1:0]     col_r;
  logic [ROW_W-1:0]  row_r;
  logic [15:0]       held_r;
  logic [15:0]       line_q_r;
  logic [15:0]       line_mem [LD];

  logic              s1_v_r;
  logic              s1_pass_r;
  csel_t             s1_sel_r;
  ysr_in_t           s1_pix_r;
  logic              s1_fe_r;

  logic              accept;
  logic [13:0]       w_eff;
  logic [12:0]       h_eff;
  logic              last_col;
  logic              last_row;
  logic              even_col;
  logic              even_row;
  logic [AW-1:0]     idx;
  logic [15:0]       incoming;
  csel_t             sel_nxt;
  logic              line_wr;
  logic [15:0]       chroma;

  assign push     = s1_v_r && q_ready;
  assign in_stall = s1_v_r && !q_ready;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = 14'd1;
    end else if ({1'b0, frame_width} > 14'(MAX_WIDTH)) begin
      w_eff = 14'(MAX_WIDTH);
    end else begin
      w_eff = {1'b0, frame_width};
    end
    if (frame_height == '0) begin
      h_eff = 13'd1;
    end else if (frame_height > 13'(HEIGHT_LIMIT)) begin
      h_eff = 13'(HEIGHT_LIMIT);
    end else begin
      h_eff = frame_height;
    end
  end

  assign last_col = (14'(col_r) + 14'd1) >= w_eff;
  assign last_row = (13'(row_r) + 13'd1) >= h_eff;
  assign even_col = !col_r[0];
  assign even_row = !row_r[0];
  assign idx      = AW'(col_r >> 1);
  assign incoming = {in_data.chroma_blue, in_data.chroma_red};

  always_comb begin
    sel_nxt = SEL_HELD;
    line_wr = 1'b0;
    case (mode)
      MODE_444: sel_nxt = SEL_IN;
      MODE_422: sel_nxt = even_col ? SEL_IN : SEL_HELD;
      MODE_420: begin
        if (even_col && even_row) begin
          sel_nxt = SEL_IN;
          line_wr = 1'b1;
        end else if (even_col) begin
          sel_nxt = SEL_LINE;
        end
      end
      default: sel_nxt = SEL_HELD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_q_r <= line_mem[idx];
      if (line_wr) begin
        line_mem[idx] <= incoming;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end else if (push) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pass_r <= (mode == MODE_RGB);
      s1_sel_r  <= sel_nxt;
      s1_pix_r  <= in_data;
      s1_fe_r   <= last_col && last_row;
    end
  end

  always_comb begin
    case (s1_sel_r)
      SEL_IN:   chroma = {s1_pix_r.chroma_blue, s1_pix_r.chroma_red};
      SEL_LINE: chroma = line_q_r;
      default:  chroma = held_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (push && !s1_pass_r) begin
      held_r <= chroma;
    end
  end

  always_comb begin
    push_item.passthru  = s1_pass_r;
    push_item.luma      = s1_pix_r.luma;
    push_item.cb        = s1_pass_r ? s1_pix_r.chroma_blue : chroma[15:8];
    push_item.cr        = s1_pass_r ? s1_pix_r.chroma_red  : chroma[7:0];
    push_item.frame_end = s1_fe_r;
  end

endmodule

FILE: hw/rtl/ysr_queue.sv
// ----------------------------------------------------------------------------
// ysr_queue
// Short FIFO that decouples pixel classification from color conversion.
// ----------------------------------------------------------------------------
module ysr_queue
  import ysr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  ysr_item_t push_item,
  output logic      q_ready,
  output logic      q_valid,
  output ysr_item_t q_item,
  input  logic      pop
);

  localparam int PW = $clog2(QDEPTH);

  ysr_item_t         slot_r [QDEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     rd_ptr_r;
  logic [PW:0]       count_r;

  assign q_ready = count_r != (PW+1)'(QDEPTH);
  assign q_valid = count_r != '0;
  assign q_item  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/ysr_back.sv
// ----------------------------------------------------------------------------
// ysr_back
// Two-stage BT.601 matrix: products, then sum, floor shift and clamp into the
// output register; passthrough pixels skip the matrix.
// ----------------------------------------------------------------------------
module ysr_back
  import ysr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  ysr_item_t q_item,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output ysr_out_t  out_data
);

  logic                p_v_r;
  logic                p_pass_r;
  logic                p_fe_r;
  logic [23:0]         p_raw_r;
  logic signed [20:0]  ty_r;
  logic signed [20:0]  tr_r;
  logic signed [20:0]  tg_r;
  logic signed [20:0]  tb_r;
  logic                out_v_r;
  ysr_out_t            out_r;

  logic                out_free;
  logic                p_free;
  logic signed [20:0]  yd;
  logic signed [20:0]  cbd;
  logic signed [20:0]  crd;
  ysr_out_t            res;

  function automatic logic [7:0] clamp8(input logic signed [20:0] v);
    logic signed [20:0] s;
    s = v >>> 8;
    if (s < 0) begin
      return 8'd0;
    end else if (s > 21'(BYTE_MAX)) begin
      return 8'(BYTE_MAX);
    end
    return s[7:0];
  endfunction

  assign out_free = !out_v_r || !out_stall;
  assign p_free   = !p_v_r || out_free;
  assign pop      = q_valid && p_free;

  assign yd  = $signed({13'd0, q_item.luma}) - 21'(Y_OFFSET);
  assign cbd = $signed({13'd0, q_item.cb})   - 21'(C_OFFSET);
  assign crd = $signed({13'd0, q_item.cr})   - 21'(C_OFFSET);

  always_ff @(posedge clk) begin
    if (pop) begin
      p_pass_r <= q_item.passthru;
      p_fe_r   <= q_item.frame_end;
      p_raw_r  <= {q_item.luma, q_item.cb, q_item.cr};
      ty_r     <= yd * 21'(COEF_Y) + 21'(ROUND_ADD);
      tr_r     <= crd * 21'(COEF_RCR);
      tg_r     <= -(cbd * 21'(COEF_GCB)) - crd * 21'(COEF_GCR);
      tb_r     <= cbd * 21'(COEF_BCB);
    end
  end

  always_comb begin
    res.frame_end = p_fe_r;
    if (p_pass_r) begin
      res.red   = p_raw_r[23:16];
      res.green = p_raw_r[15:8];
      res.blue  = p_raw_r[7:0];
    end else begin
      res.red   = clamp8(ty_r + tr_r);
      res.green = clamp8(ty_r + tg_r);
      res.blue  = clamp8(ty_r + tb_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (p_free) begin
        p_v_r <= q_valid;
      end
      if (out_free) begin
        out_v_r <= p_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && p_v_r) begin
      out_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

FILE: hw/rtl/ysr_checker.sv
// ----------------------------------------------------------------------------
// ysr_checker
// Port-level checks for the YCbCr to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
module ysr_checker
  import ysr_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input ysr_out_t out_data
);

  // s1, queue, product and output registers: nothing leaves right after reset
  a_no_early_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid ##1 !out_valid ##1 !out_valid)
    else $error("result beat too soon after reset");

  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result payload changed while stalled");

endmodule

bind ycbcr_subsampled_to_rgb ysr_checker u_ysr_checker (.*);

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ycbcr_subsampled_to_rgb. A driver sends pixel beats
// from a queue, a scoreboard-side model works out the RGB pixel and frame_end
// for every accepted beat, and a monitor compares each output beat in order.
// Covers all subsampling modes, odd and out-of-range frame sizes, random
// stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import ysr_pkg::*;

  localparam int LINE_DEPTH  = MAX_WIDTH_DEF / 2;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PIXEL_GOAL  = 925;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  ysr_in_t             in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ysr_out_t            out_data;
  logic                cfg_we = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr = REG_MODE;
  logic [CFG_DW-1:0]   cfg_wdata = '0;

  ycbcr_subsampled_to_rgb DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // converter model state
  mode_t       mode_reg = MODE_420;
  int          wid_reg = WIDTH_RST;
  int          hgt_reg = HEIGHT_RST;
  int          col_pos = 0;
  int          row_pos = 0;
  logic [15:0] chroma_hold = '0;
  logic [15:0] saved_chroma [0:LINE_DEPTH-1];
  bit          saved_valid [0:LINE_DEPTH-1];

  ysr_in_t     pixel_queue[$];
  ysr_out_t    rgb_expected[$];
  int          issued = 0;
  int          beats_in = 0;
  int          beats_out = 0;
  int          mismatches = 0;
  int          cycles = 0;
  int          send_idle_pct = 34;
  int          recv_idle_pct = 49;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int eff_size(int raw, int cap);
    if (raw == 0) return 1;
    if (raw > cap) return cap;
    return raw;
  endfunction

  function automatic logic [7:0] clamp8(int v);
    if (v < 0) return 8'd0;
    if (v > BYTE_MAX) return 8'd255;
    return v[7:0];
  endfunction

  function automatic ysr_out_t convert_pixel(ysr_in_t px);
    int       w;
    int       h;
    int       yd;
    int       cbd;
    int       crd;
    bit       last_c;
    bit       last_r;
    ysr_out_t res;
    w = eff_size(wid_reg, MAX_WIDTH_DEF);
    h = eff_size(hgt_reg, HEIGHT_LIMIT);
    if (mode_reg == MODE_RGB) begin
      res.red   = px.luma;
      res.green = px.chroma_blue;
      res.blue  = px.chroma_red;
    end else begin
      case (mode_reg)
        MODE_444: chroma_hold = {px.chroma_blue, px.chroma_red};
        MODE_422: begin
          if (col_pos[0] == 1'b0) chroma_hold = {px.chroma_blue, px.chroma_red};
        end
        default: begin
          if (col_pos[0] == 1'b0) begin
            if (row_pos[0] == 1'b0) begin
              chroma_hold = {px.chroma_blue, px.chroma_red};
              saved_chroma[col_pos >> 1] = chroma_hold;
              saved_valid[col_pos >> 1] = 1'b1;
            end else begin
              chroma_hold = saved_chroma[col_pos >> 1];
            end
          end
        end
      endcase
      yd  = int'(px.luma) - Y_OFFSET;
      cbd = int'(chroma_hold[15:8]) - C_OFFSET;
      crd = int'(chroma_hold[7:0]) - C_OFFSET;
      res.red   = clamp8((COEF_Y * yd + COEF_RCR * crd + ROUND_ADD) >>> 8);
      res.green = clamp8((COEF_Y * yd - COEF_GCB * cbd - COEF_GCR * crd + ROUND_ADD) >>> 8);
      res.blue  = clamp8((COEF_Y * yd + COEF_BCB * cbd + ROUND_ADD) >>> 8);
    end
    last_c = (col_pos + 1 >= w);
    last_r = (row_pos + 1 >= h);
    res.frame_end = last_c && last_r;
    if (last_c) begin
      col_pos = 0;
      row_pos = last_r ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return res;
  endfunction

  // In 4:2:0, an odd row must only read line entries written earlier. Walk
  // ahead from the current position until an even row starts at column 0.
  function automatic bit line_reads_safe(mode_t m, int w_raw, int h_raw);
    int w;
    int h;
    int c;
    int r;
    bit seen [0:LINE_DEPTH-1];
    w = eff_size(w_raw, MAX_WIDTH_DEF);
    h = eff_size(h_raw, HEIGHT_LIMIT);
    c = col_pos;
    r = row_pos;
    seen = saved_valid;
    if (m != MODE_420) return 1'b1;
    for (int k = 0; k < 3 * MAX_WIDTH_DEF + 8; k++) begin
      if (c == 0 && r % 2 == 0) return 1'b1;
      if (c % 2 == 0) begin
        if (r % 2 == 0) seen[c >> 1] = 1'b1;
        else if (!seen[c >> 1]) return 1'b0;
      end
      if (c + 1 >= w) begin
        c = 0;
        r = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        c = c + 1;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int pick_size(int small_max, int cap);
    int r;
    r = $urandom_range(0, 19);
    if (r < 13) return $urandom_range(1, small_max);
    if (r < 16) return $urandom_range(small_max + 1, 64);
    if (r == 16) return 0;
    if (r == 17) return cap;
    if (r == 18) return ($urandom_range(0, 1) != 0) ? 8191 : $urandom_range(cap + 1, 8191);
    return $urandom_range(1, cap);
  endfunction

  task automatic set_reg(logic [CFG_AW-1:0] addr, int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val[CFG_DW-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (addr)
      REG_MODE:  mode_reg = mode_t'(val[1:0]);
      REG_WIDTH: wid_reg = val & 32'h1FFF;
      default:   hgt_reg = val & 32'h1FFF;
    endcase
  endtask

  task automatic configure(mode_t m, int w, int h);
    set_reg(REG_MODE, int'(m));
    set_reg(REG_WIDTH, w);
    set_reg(REG_HEIGHT, h);
  endtask

  task automatic add_pixel(logic [7:0] y, logic [7:0] cb, logic [7:0] cr);
    pixel_queue.push_back('{luma: y, chroma_blue: cb, chroma_red: cr});
    issued++;
    if (issued < 300) begin
      send_idle_pct = 34;
      recv_idle_pct = 49;
    end else if (issued < 600) begin
      send_idle_pct = 49;
      recv_idle_pct = 34;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  task automatic drain();
    while (beats_in != issued || rgb_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // driver: predict on acceptance, then offer the next beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        rgb_expected.push_back(convert_pixel(in_data));
        beats_in++;
      end
      if (!in_valid || !in_stall) begin
        if (pixel_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pixel_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off while the sender keeps going
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && beats_out >= 300 && pixel_queue.size() >= 20) begin
      hold_done = 1'b1;
      hold_left = 120;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    ysr_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      beats_out++;
      if (rgb_expected.size() == 0) begin
        $error("out beat: no pixel expected, got %h", out_data);
        mismatches++;
      end else begin
        want = rgb_expected.pop_front();
        if (out_data.red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, out_data.red);
          mismatches++;
        end
        if (out_data.green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, out_data.green);
          mismatches++;
        end
        if (out_data.blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, out_data.blue);
          mismatches++;
        end
        if (out_data.frame_end !== want.frame_end) begin
          $error("frame_end: expected %0d, got %0d", want.frame_end, out_data.frame_end);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    mode_t m;
    int    w;
    int    h;
    int    n;
    int    tries;
    for (int i = 0; i < LINE_DEPTH; i++) begin
      saved_chroma[i] = '0;
      saved_valid[i]  = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: byte extremes in 4:4:4, passthrough, 4:2:2, a full 4:2:0 frame
    configure(MODE_444, 3, 2);
    for (int i = 0; i < 8; i++) begin
      add_pixel(i[2] ? 8'd255 : 8'd0, i[1] ? 8'd255 : 8'd0, i[0] ? 8'd255 : 8'd0);
    end
    add_pixel(8'd16, 8'd128, 8'd128);
    add_pixel(8'd235, 8'd240, 8'd16);
    drain();
    configure(MODE_RGB, 2, 1);
    add_pixel(8'd255, 8'd0, 8'd165);
    add_pixel(8'd0, 8'd255, 8'd90);
    add_pixel(8'd18, 8'd52, 8'd86);
    drain();
    configure(MODE_422, 3, 1);
    add_pixel(8'd81, 8'd90, 8'd240);
    add_pixel(8'd145, 8'd54, 8'd34);
    add_pixel(8'd41, 8'd240, 8'd110);
    drain();
    configure(MODE_420, 3, 3);
    for (int k = 0; k < 9; k++) begin
      add_pixel(8'(k * 28), 8'(255 - k * 20), 8'(k * 30));
    end
    drain();

    // random phases, each with its own setting
    while (issued < PIXEL_GOAL) begin
      tries = 0;
      do begin
        m = mode_t'($urandom_range(0, 3));
        w = pick_size(8, MAX_WIDTH_DEF);
        h = pick_size(6, HEIGHT_LIMIT);
        tries++;
        if (tries > 20) m = MODE_444;
      end while (!line_reads_safe(m, w, h));
      configure(m, w, h);
      n = $urandom_range(20, 120);
      for (int k = 0; k < n; k++) add_pixel(pick_byte(), pick_byte(), pick_byte());
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/ysr_pkg.sv
hw/rtl/ysr_front.sv
hw/rtl/ysr_queue.sv
hw/rtl/ysr_back.sv
hw/rtl/ycbcr_subsampled_to_rgb.sv
hw/rtl/ysr_checker.sv
verif/testbench.sv
